[src/ctpi_pkg.sv]
// Shared types, widths and constants for the moving-circle time-of-impact core.
package ctpi_pkg;

    localparam int PosW    = 16;
    localparam int RadW    = 15;
    localparam int DiffW   = PosW + 1;
    localparam int SumRadW = RadW + 1;
    localparam int ProdW   = 2 * DiffW;
    localparam int MagW    = 33;
    localparam int HW      = MagW + 2;
    localparam int LoW     = 17;
    localparam int HiW     = MagW - LoW;
    localparam int DW      = 2 * MagW + 1;
    localparam int TrialW  = DW + 1;
    localparam int RootW   = 34;
    localparam int NumW    = RootW + 2;
    localparam int FracBits = 16;
    localparam int ScW     = NumW + FracBits;
    localparam int QW      = 32;
    localparam int RemW    = MagW + QW + 1;

    localparam logic [QW-1:0] TimeMax = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] TimeMin = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_NONE   = 2'd0,
        STATUS_LINEAR = 2'd1,
        STATUS_ROOT   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PosW-1:0] first_x;
        logic signed [PosW-1:0] first_y;
        logic signed [PosW-1:0] first_vx;
        logic signed [PosW-1:0] first_vy;
        logic [RadW-1:0]        first_radius;
        logic signed [PosW-1:0] second_x;
        logic signed [PosW-1:0] second_y;
        logic signed [PosW-1:0] second_vx;
        logic signed [PosW-1:0] second_vy;
        logic [RadW-1:0]        second_radius;
    } ctpi_request_t;

    typedef struct packed {
        logic signed [QW-1:0] impact_time;
        status_t              status;
        logic                 saturated;
    } ctpi_result_t;

    typedef struct packed {
        logic                 ok;
        logic signed [HW-1:0] h;
        logic [MagW-1:0]      a;
    } ctpi_sqrt_side_t;

    typedef struct packed {
        logic ok;
        logic neg;
        logic ovf;
    } ctpi_div_flags_t;

endpackage

[src/ctpi_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module ctpi_sqrt
    import ctpi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            radicand_valid,
    input  logic [DW-1:0]   radicand,
    input  ctpi_sqrt_side_t radicand_side,
    output logic            root_valid,
    output logic [RootW-1:0] root,
    output ctpi_sqrt_side_t root_side
);

    logic [DW-1:0]    rem_reg   [RootW];
    logic [DW-1:0]    rem_next  [RootW];
    logic [RootW-1:0] root_reg  [RootW];
    logic [RootW-1:0] root_next [RootW];
    ctpi_sqrt_side_t  side_reg  [RootW];
    logic [RootW-1:0] valid_reg;
    logic [RootW-1:0] valid_next;

    for (genvar i = 0; i < RootW; i++)
    begin : g_stage
        localparam int Bit = RootW - 1 - i;
        logic [DW-1:0]     rem_in;
        logic [RootW-1:0]  root_in;
        ctpi_sqrt_side_t   side_in;
        logic [TrialW-1:0] trial;
        logic              fits;

        if (i == 0)
        begin : g_first
            assign rem_in        = radicand;
            assign root_in       = '0;
            assign side_in       = radicand_side;
            assign valid_next[i] = radicand_valid;
        end
        else
        begin : g_rest
            assign rem_in        = rem_reg[i-1];
            assign root_in       = root_reg[i-1];
            assign side_in       = side_reg[i-1];
            assign valid_next[i] = valid_reg[i-1];
        end

        always_comb
        begin
            trial = (TrialW'(root_in) << (Bit + 1)) | (TrialW'(1) << (2 * Bit));
            fits  = TrialW'(rem_in) >= trial;
            rem_next[i]  = fits ? DW'(TrialW'(rem_in) - trial) : rem_in;
            root_next[i] = root_in | (RootW'(fits) << Bit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                side_reg[i] <= side_in;
            end
        end
    end

    assign root_valid = valid_reg[RootW-1];
    assign root       = root_reg[RootW-1];
    assign root_side  = side_reg[RootW-1];

endmodule

[src/ctpi_div.sv]
// Pipelined signed divider of the scaled numerator by A, one quotient bit per stage.
module ctpi_div
    import ctpi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   num_valid,
    input  logic signed [NumW-1:0] num,
    input  logic [MagW-1:0]        divisor,
    input  logic                   num_ok,
    output logic                   quot_valid,
    output logic [QW-1:0]          quotient,
    output ctpi_div_flags_t        quot_flags
);

    logic                  abs_valid_reg;
    logic [NumW-1:0]       mag_reg;
    logic [NumW-1:0]       mag_next;
    logic [MagW-1:0]       abs_a_reg;
    ctpi_div_flags_t       abs_flags_reg;

    logic                  pre_valid_reg;
    logic [RemW-1:0]       pre_rem_reg;
    logic [RemW-1:0]       pre_rem_next;
    logic [MagW-1:0]       pre_a_reg;
    ctpi_div_flags_t       pre_flags_reg;
    ctpi_div_flags_t       pre_flags_next;

    logic [RemW-1:0]       rem_reg   [QW];
    logic [RemW-1:0]       rem_next  [QW];
    logic [QW-1:0]         q_reg     [QW];
    logic [QW-1:0]         q_next    [QW];
    logic [MagW-1:0]       a_reg     [QW];
    ctpi_div_flags_t       flags_reg [QW];
    logic [QW-1:0]         valid_reg;
    logic [QW-1:0]         valid_next;

    always_comb
    begin
        mag_next = num[NumW-1] ? NumW'(-num) : NumW'(num);
    end

    always_comb
    begin
        pre_rem_next       = RemW'(mag_reg) << FracBits;
        pre_flags_next     = abs_flags_reg;
        pre_flags_next.ovf = pre_rem_next >= (RemW'(abs_a_reg) << QW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg <= 1'b0;
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            abs_valid_reg <= num_valid;
            pre_valid_reg <= abs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg           <= mag_next;
            abs_a_reg         <= divisor;
            abs_flags_reg.ok  <= num_ok;
            abs_flags_reg.neg <= num[NumW-1];
            abs_flags_reg.ovf <= 1'b0;
            pre_rem_reg       <= pre_rem_next;
            pre_a_reg         <= abs_a_reg;
            pre_flags_reg     <= pre_flags_next;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int Bit = QW - 1 - i;
        logic [RemW-1:0]  rem_in;
        logic [QW-1:0]    q_in;
        logic [MagW-1:0]  a_in;
        ctpi_div_flags_t  flags_in;
        logic [RemW-1:0]  shifted;
        logic             fits;

        if (i == 0)
        begin : g_first
            assign rem_in        = pre_rem_reg;
            assign q_in          = '0;
            assign a_in          = pre_a_reg;
            assign flags_in      = pre_flags_reg;
            assign valid_next[i] = pre_valid_reg;
        end
        else
        begin : g_rest
            assign rem_in        = rem_reg[i-1];
            assign q_in          = q_reg[i-1];
            assign a_in          = a_reg[i-1];
            assign flags_in      = flags_reg[i-1];
            assign valid_next[i] = valid_reg[i-1];
        end

        always_comb
        begin
            shifted     = RemW'(a_in) << Bit;
            fits        = rem_in >= shifted;
            rem_next[i] = fits ? (rem_in - shifted) : rem_in;
            q_next[i]   = q_in | (QW'(fits) << Bit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= rem_next[i];
                q_reg[i]     <= q_next[i];
                a_reg[i]     <= a_in;
                flags_reg[i] <= flags_in;
            end
        end
    end

    assign quot_valid = valid_reg[QW-1];
    assign quotient   = q_reg[QW-1];
    assign quot_flags = flags_reg[QW-1];

endmodule

[src/circle_pair_time_of_impact_core.sv]
// Top level of the moving-circle time-of-impact core: setup, discriminant, root pick, clip.
//
//   channel   valid          stall          payload   type
//   in        request_valid  request_stall  request   ctpi_request_t
//   out       result_valid   result_stall   result    ctpi_result_t
//
// One request enters per cycle unless a stalled result holds the pipeline; the
// depth is set by the 34-stage square root and the 34-stage divider.
// Reset clears only the valid bits; the pipeline comes up empty.
// A stalled result freezes the whole pipeline; request_stall follows it.
module circle_pair_time_of_impact_core
    import ctpi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          request_valid,
    output logic          request_stall,
    input  ctpi_request_t request,
    output logic          result_valid,
    input  logic          result_stall,
    output ctpi_result_t  result
);

    logic adv;

    // stage 1: differences
    logic v1_reg;
    logic signed [DiffW-1:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic [SumRadW-1:0] rs_reg;

    // stage 2: products
    logic v2_reg;
    logic signed [ProdW-1:0] dvx2_reg, dvy2_reg, hx_reg, hy_reg, dx2_reg, dy2_reg;
    logic signed [ProdW-1:0] dvx2_next, dvy2_next, hx_next, hy_next, dx2_next, dy2_next;
    logic [2*SumRadW-1:0] rs2_reg;

    // stage 3: coefficients
    logic v3_reg;
    logic [MagW-1:0] a3_reg;
    logic signed [HW-1:0] h3_reg, c3_reg;
    logic signed [HW-1:0] a3_next, h3_next, c3_next;

    // stage 4: magnitudes
    logic v4_reg;
    logic [MagW-1:0] a4_reg, habs_reg, cabs_reg;
    logic signed [HW-1:0] h4_reg;
    logic cneg4_reg, anz4_reg;

    // stage 5: partial products
    logic v5_reg;
    logic [2*LoW-1:0] hll_reg, all_reg;
    logic [LoW+HiW-1:0] hlh_reg, alh_reg, ahl_reg;
    logic [2*HiW-1:0] hhh_reg, ahh_reg;
    logic [MagW-1:0] a5_reg;
    logic signed [HW-1:0] h5_reg;
    logic cneg5_reg, anz5_reg;

    // stage 6: squares
    logic v6_reg;
    logic [DW-1:0] hsq_reg, ac_reg;
    logic [MagW-1:0] a6_reg;
    logic signed [HW-1:0] h6_reg;
    logic cneg6_reg, anz6_reg;

    // stage 7: discriminant
    logic v7_reg;
    logic [DW-1:0] d_reg, d_next;
    ctpi_sqrt_side_t side7_reg, side7_next;

    logic            sq_valid;
    logic [RootW-1:0] sq_root;
    ctpi_sqrt_side_t sq_side;

    // root candidates
    logic vn_reg;
    logic signed [NumW-1:0] n1_reg, n2_reg, n1_next, n2_next;
    logic [MagW-1:0] an_reg;
    logic okn_reg;

    logic vp_reg;
    logic signed [NumW-1:0] num_reg, num_next;
    logic [MagW-1:0] ap_reg;
    logic okp_reg;

    logic            dv_valid;
    logic [QW-1:0]   dv_quot;
    ctpi_div_flags_t dv_flags;

    logic         out_valid_reg;
    ctpi_result_t out_reg, out_next;

    assign adv           = !(out_valid_reg && result_stall);
    assign request_stall = !adv;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    always_comb
    begin
        dvx2_next = dvx_reg * dvx_reg;
        dvy2_next = dvy_reg * dvy_reg;
        hx_next   = dx_reg * dvx_reg;
        hy_next   = dy_reg * dvy_reg;
        dx2_next  = dx_reg * dx_reg;
        dy2_next  = dy_reg * dy_reg;
    end

    always_comb
    begin
        a3_next = HW'(dvx2_reg) + HW'(dvy2_reg);
        h3_next = HW'(hx_reg) + HW'(hy_reg);
        c3_next = HW'(dx2_reg) + HW'(dy2_reg) - $signed(HW'(rs2_reg));
    end

    always_comb
    begin
        logic [DW-1:0] sum;
        logic [DW-1:0] diff;
        sum  = hsq_reg + ac_reg;
        diff = hsq_reg - ac_reg;
        side7_next.h = h6_reg;
        side7_next.a = a6_reg;
        if (cneg6_reg)
        begin
            d_next        = sum;
            side7_next.ok = anz6_reg;
        end
        else
        begin
            d_next        = diff;
            side7_next.ok = anz6_reg && (ac_reg <= hsq_reg);
        end
    end

    always_comb
    begin
        n1_next = -NumW'(sq_side.h) - $signed(NumW'(sq_root));
        n2_next = -NumW'(sq_side.h) + $signed(NumW'(sq_root));
    end

    always_comb
    begin
        logic [ScW-1:0] n1_scaled;
        n1_scaled = {n1_reg, {FracBits{1'b0}}};
        if (!n1_reg[NumW-1] && (n1_scaled >= ScW'(an_reg)))
        begin
            num_next = n1_reg;
        end
        else
        begin
            num_next = n2_reg;
        end
    end

    always_comb
    begin
        out_next.impact_time = '0;
        out_next.status      = STATUS_NONE;
        out_next.saturated   = 1'b0;
        if (dv_flags.ok)
        begin
            out_next.status = STATUS_ROOT;
            if (dv_flags.neg)
            begin
                if (dv_flags.ovf || (dv_quot[QW-1] && (|dv_quot[QW-2:0])))
                begin
                    out_next.impact_time = TimeMin;
                    out_next.saturated   = 1'b1;
                end
                else
                begin
                    out_next.impact_time = -dv_quot;
                end
            end
            else
            begin
                if (dv_flags.ovf || dv_quot[QW-1])
                begin
                    out_next.impact_time = TimeMax;
                    out_next.saturated   = 1'b1;
                end
                else
                begin
                    out_next.impact_time = dv_quot;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            vn_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= request_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            vn_reg        <= sq_valid;
            vp_reg        <= vn_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= DiffW'(request.first_x) - DiffW'(request.second_x);
            dy_reg  <= DiffW'(request.first_y) - DiffW'(request.second_y);
            dvx_reg <= DiffW'(request.first_vx) - DiffW'(request.second_vx);
            dvy_reg <= DiffW'(request.first_vy) - DiffW'(request.second_vy);
            rs_reg  <= SumRadW'(request.first_radius) + SumRadW'(request.second_radius);

            dvx2_reg <= dvx2_next;
            dvy2_reg <= dvy2_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
            dx2_reg  <= dx2_next;
            dy2_reg  <= dy2_next;
            rs2_reg  <= rs_reg * rs_reg;

            a3_reg <= a3_next[MagW-1:0];
            h3_reg <= h3_next;
            c3_reg <= c3_next;

            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            habs_reg  <= h3_reg[HW-1] ? MagW'(-h3_reg) : MagW'(h3_reg);
            cabs_reg  <= c3_reg[HW-1] ? MagW'(-c3_reg) : MagW'(c3_reg);
            cneg4_reg <= c3_reg[HW-1];
            anz4_reg  <= |a3_reg;

            hll_reg   <= habs_reg[LoW-1:0] * habs_reg[LoW-1:0];
            hlh_reg   <= habs_reg[LoW-1:0] * habs_reg[MagW-1:LoW];
            hhh_reg   <= habs_reg[MagW-1:LoW] * habs_reg[MagW-1:LoW];
            all_reg   <= a4_reg[LoW-1:0] * cabs_reg[LoW-1:0];
            alh_reg   <= a4_reg[LoW-1:0] * cabs_reg[MagW-1:LoW];
            ahl_reg   <= a4_reg[MagW-1:LoW] * cabs_reg[LoW-1:0];
            ahh_reg   <= a4_reg[MagW-1:LoW] * cabs_reg[MagW-1:LoW];
            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
            cneg5_reg <= cneg4_reg;
            anz5_reg  <= anz4_reg;

            hsq_reg   <= (DW'(hhh_reg) << (2 * LoW)) + (DW'(hlh_reg) << (LoW + 1))
                         + DW'(hll_reg);
            ac_reg    <= (DW'(ahh_reg) << (2 * LoW)) + (DW'(alh_reg) << LoW)
                         + (DW'(ahl_reg) << LoW) + DW'(all_reg);
            a6_reg    <= a5_reg;
            h6_reg    <= h5_reg;
            cneg6_reg <= cneg5_reg;
            anz6_reg  <= anz5_reg;

            d_reg     <= d_next;
            side7_reg <= side7_next;

            n1_reg  <= n1_next;
            n2_reg  <= n2_next;
            an_reg  <= sq_side.a;
            okn_reg <= sq_side.ok;

            num_reg <= num_next;
            ap_reg  <= an_reg;
            okp_reg <= okn_reg;

            out_reg <= out_next;
        end
    end

    ctpi_sqrt u_sqrt (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .radicand_valid (v7_reg),
        .radicand       (d_reg),
        .radicand_side  (side7_reg),
        .root_valid     (sq_valid),
        .root           (sq_root),
        .root_side      (sq_side)
    );

    ctpi_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .num_valid  (vp_reg),
        .num        (num_reg),
        .divisor    (ap_reg),
        .num_ok     (okp_reg),
        .quot_valid (dv_valid),
        .quotient   (dv_quot),
        .quot_flags (dv_flags)
    );

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_NONE)
        |-> (result.impact_time == '0) && !result.saturated)
        else $error("no-solution result carries a time or saturation");

    a_no_linear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status != STATUS_LINEAR))
        else $error("linear status with nonzero relative velocity");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated
        |-> (result.impact_time == TimeMax) || (result.impact_time == TimeMin))
        else $error("saturated time is not a range limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> result_valid && result_stall)
        else $error("request stalled without a stalled result");

endmodule
